[rtl/ps2fr_pkg.sv]
// Shared types and constants for the PS/2 frame receiver.
`timescale 1ns / 1ps

package ps2fr_pkg;

    typedef enum logic [1:0] {
        OP_EDGE  = 2'd0,
        OP_TICK  = 2'd1,
        OP_POP   = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    localparam int unsigned TIMEOUT_W = 10;
    localparam int unsigned IDX_W     = 4;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET  = 10'd250;
    localparam logic [TIMEOUT_W-1:0] IDLE_MAX       = 10'd1023;
    localparam logic [IDX_W-1:0]     FRAME_EDGES    = 4'd11;
    localparam logic [IDX_W-1:0]     LAST_DATA_EDGE = 4'd8;

    typedef struct packed {
        logic       push;
        logic [7:0] data;
    } push_t;

    typedef struct packed {
        logic       frame_dropped;
        logic       byte_valid;
        logic [7:0] byte_out;
    } result_t;

endpackage

[rtl/ps2fr_frame.sv]
// Frame assembler: idle timer, timeout restart and bit shifter.
`timescale 1ns / 1ps

module ps2fr_frame (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [ps2fr_pkg::TIMEOUT_W-1:0] cfg_wdata,
    input  logic                            step,
    input  ps2fr_pkg::op_t                  op,
    input  logic                            data_bit,
    output ps2fr_pkg::push_t                push
);
    import ps2fr_pkg::*;

    logic [TIMEOUT_W-1:0] timeout_reg;
    logic [7:0]           shift_reg, shift_next;
    logic [IDX_W-1:0]     index_reg, index_next;
    logic [TIMEOUT_W-1:0] idle_reg, idle_next;

    logic                 restart;
    logic [7:0]           shift_base, shift_new;
    logic [IDX_W-1:0]     index_base, index_inc;

    always_comb
    begin
        restart    = idle_reg > timeout_reg;
        shift_base = restart ? 8'd0 : shift_reg;
        index_base = restart ? '0 : index_reg;
        for (int i = 0; i < 8; i++)
        begin
            shift_new[i] = shift_base[i]
                | (data_bit && (index_base == IDX_W'(i + 1))
                   && (index_base <= LAST_DATA_EDGE));
        end
        index_inc = index_base + IDX_W'(1);

        shift_next = shift_reg;
        index_next = index_reg;
        idle_next  = idle_reg;
        push.push  = 1'b0;
        push.data  = shift_new;

        if (step)
        begin
            case (op)
                OP_EDGE:
                begin
                    idle_next = '0;
                    if (index_inc >= FRAME_EDGES)
                    begin
                        push.push  = 1'b1;
                        shift_next = 8'd0;
                        index_next = '0;
                    end
                    else
                    begin
                        shift_next = shift_new;
                        index_next = index_inc;
                    end
                end
                OP_TICK:
                begin
                    if (idle_reg < IDLE_MAX)
                        idle_next = idle_reg + TIMEOUT_W'(1);
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
            shift_reg   <= 8'd0;
            index_reg   <= '0;
            idle_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
                timeout_reg <= cfg_wdata;
            shift_reg <= shift_next;
            index_reg <= index_next;
            idle_reg  <= idle_next;
        end
    end

endmodule

[rtl/ps2fr_ring.sv]
// Byte ring with one spare slot, registered read data and result flags.
`timescale 1ns / 1ps

module ps2fr_ring #(
    parameter int unsigned RING_DEPTH = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  ps2fr_pkg::op_t     op,
    input  ps2fr_pkg::push_t   push,
    output ps2fr_pkg::result_t result
);
    import ps2fr_pkg::*;

    localparam int unsigned AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam logic [AW-1:0] LAST_SLOT = AW'(RING_DEPTH - 1);

    logic [7:0]    mem [RING_DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [7:0]    rd_data_reg;
    logic          valid_reg, valid_next;
    logic          dropped_reg, dropped_next;

    logic [AW-1:0] wr_succ, rd_succ;
    logic          mem_we;

    always_comb
    begin
        wr_succ = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + AW'(1);
        rd_succ = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + AW'(1);

        wr_ptr_next  = wr_ptr_reg;
        rd_ptr_next  = rd_ptr_reg;
        valid_next   = valid_reg;
        dropped_next = dropped_reg;
        mem_we       = 1'b0;

        if (step)
        begin
            valid_next   = 1'b0;
            dropped_next = 1'b0;
            case (op)
                OP_EDGE:
                begin
                    if (push.push)
                    begin
                        if (wr_succ != rd_ptr_reg)
                        begin
                            mem_we      = 1'b1;
                            wr_ptr_next = wr_succ;
                        end
                        else
                        begin
                            dropped_next = 1'b1;
                        end
                    end
                end
                OP_POP:
                begin
                    if (rd_ptr_reg != wr_ptr_reg)
                    begin
                        valid_next  = 1'b1;
                        rd_ptr_next = rd_succ;
                    end
                end
                OP_CLEAR:
                begin
                    wr_ptr_next = '0;
                    rd_ptr_next = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wr_succ] <= push.data;
        if (step)
            rd_data_reg <= mem[rd_succ];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            valid_reg   <= 1'b0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            wr_ptr_reg  <= wr_ptr_next;
            rd_ptr_reg  <= rd_ptr_next;
            valid_reg   <= valid_next;
            dropped_reg <= dropped_next;
        end
    end

    assign result.byte_out      = valid_reg ? rd_data_reg : 8'd0;
    assign result.byte_valid    = valid_reg;
    assign result.frame_dropped = dropped_reg;

endmodule

[rtl/ps2_frame_receiver_fifo.sv]
// Top level of the PS/2 frame receiver with byte ring.
//
//  channel | direction | tdata             | tuser
//  s_      | in        | [0] data_bit      | [1:0] opcode
//  m_      | out       | [7:0] byte_out    | [0] byte_valid, [1] frame_dropped
//  cfg_    | in        | idle_timeout_ms   | -
//
// One word accepted per cycle unless the result stalls; each result word is registered.
// The input register feeds the assembler and ring; ring read data is registered
// straight into the result. A stalled result holds the input register, which
// keeps one more word. Reset clears pointers and frame state; no clearing pass.
`timescale 1ns / 1ps

module ps2_frame_receiver_fifo #(
    parameter int unsigned RING_DEPTH = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,  // [0] data_bit
    input  logic [1:0]                      s_tuser,  // [1:0] opcode
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tdata,  // [7:0] byte_out
    output logic [1:0]                      m_tuser,  // [0] byte_valid, [1] frame_dropped
    input  logic                            cfg_we,
    input  logic [ps2fr_pkg::TIMEOUT_W-1:0] cfg_wdata
);
    import ps2fr_pkg::*;

    logic    in_valid_reg;
    op_t     op_reg;
    logic    bit_reg;
    logic    out_valid_reg, out_valid_next;
    logic    step;
    push_t   push;
    result_t result;

    assign step     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (step)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            op_reg  <= op_t'(s_tuser);
            bit_reg <= s_tdata[0];
        end
    end

    ps2fr_frame u_frame (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .step      (step),
        .op        (op_reg),
        .data_bit  (bit_reg),
        .push      (push)
    );

    ps2fr_ring #(
        .RING_DEPTH (RING_DEPTH)
    ) u_ring (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .op     (op_reg),
        .push   (push),
        .result (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = result.byte_out;
    assign m_tuser  = {result.frame_dropped, result.byte_valid};

`ifndef SYNTH
    a_step_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> m_tvalid)
        else $error("processed word produced no result");

    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !step) |=> in_valid_reg)
        else $error("pending input word lost while stalled");

    a_pop_xor_drop: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("result flags both pop and drop");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == 8'd0))
        else $error("non-zero byte without valid pop");

    a_push_only_on_edge: assert property (@(posedge clk) disable iff (!rst_n)
        push.push |-> (step && (op_reg == OP_EDGE)))
        else $error("frame push outside an edge word");
`endif

endmodule
